// ===== hdl/cpr_pkg.sv =====
`default_nettype none
package cpr_pkg;
	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_TOUCH = 2'd2,
		KIND_EVICT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;
endpackage
`default_nettype wire

// ===== hdl/cpr_ram.sv =====
`default_nettype none
module cpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/clock_page_replacement_top.sv =====
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | kind, frame_addr, is_anon, is_write
// out     | out_valid | out_stall | status, victim_frame, needs_swap
// one item at a time; each slot access is a registered read of the slot memories
// add: write the free slot from a priority encoder, then link it after the tail if any
// free and touch: each ring entry examined is read, then checked; a free then unlinks it
// evict: read the hand entry, step past accessed entries, then unlink (not if last)
// reset clears only state, valid flags, head/tail/hand pointers and count; memories need none
// the result waits in an output register and the block idles until it is taken
`default_nettype none
module clock_page_replacement_top #(
	parameter int FRAMES     = 64,
	parameter int FRAME_BITS = 20
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire cpr_pkg::kind_t          kind,
	input  wire logic [FRAME_BITS-1:0]   frame_addr,
	input  wire logic                    is_anon,
	input  wire logic                    is_write,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output cpr_pkg::status_t             status,
	output logic      [FRAME_BITS-1:0]   victim_frame,
	output logic                         needs_swap
);
	import cpr_pkg::*;

	localparam int SB = $clog2(FRAMES);
	localparam int CB = $clog2(FRAMES + 1);
	localparam int NW = FRAME_BITS + SB + 3;

	typedef enum logic [3:0] {
		S_IDLE, S_FREE_SLOT, S_LINK, S_RD, S_CHECK, S_UNLINK_P, S_UNLINK_N, S_OUT
	} state_t;

	state_t state_q;
	kind_t kind_q;
	logic [FRAME_BITS-1:0] addr_q;
	logic anon_q, write_q;
	logic [FRAMES-1:0] valid_q;
	logic [SB-1:0] head_q, tail_q, hand_q, cur_q, slot_q;
	logic hand_valid_q;
	logic [CB-1:0] count_q, walk_q;
	logic evict_q;

	// memory entry: frame, next, accessed, dirty, anon
	logic          m_we;
	logic [SB-1:0] m_waddr, m_raddr;
	logic [NW-1:0] m_wdata, m_rdata;
	logic [FRAME_BITS-1:0] rd_frame;
	logic [SB-1:0] rd_next, rd_prev;
	logic rd_acc, rd_dirty, rd_anon;
	// prev links sit in a second memory so they can be written alone
	logic          l_we;
	logic [SB-1:0] l_waddr, l_raddr;
	logic [SB-1:0] l_wdata, l_rdata;

	cpr_ram #(.WIDTH(NW), .DEPTH(FRAMES)) u_nxt (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);
	cpr_ram #(.WIDTH(SB), .DEPTH(FRAMES)) u_prv (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);
	assign rd_frame = m_rdata[NW-1:SB+3];
	assign rd_next  = m_rdata[SB+2:3];
	assign rd_acc   = m_rdata[2];
	assign rd_dirty = m_rdata[1];
	assign rd_anon  = m_rdata[0];
	assign rd_prev  = l_rdata;

	logic hit;
	assign hit = valid_q[cur_q] && rd_frame == addr_q;

	// lowest free slot
	logic [SB-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SB'(i);
			end
		end
	end

	// second pointer update of the add and unlink sequences
	logic [SB-1:0] up_slot_q, up_next_q;
	logic [FRAME_BITS-1:0] up_frame_q;
	logic [2:0] up_flags_q;
	logic up_next_we_q;

	always_comb begin
		m_we = 1'b0;
		m_waddr = slot_q;
		m_wdata = {addr_q, head_q, 1'b0, 1'b0, anon_q};
		l_we = 1'b0;
		l_waddr = slot_q;
		l_wdata = tail_q;
		m_raddr = cur_q;
		l_raddr = cur_q;
		unique case (state_q)
			S_FREE_SLOT: begin
				m_we = 1'b1;
				l_we = 1'b1;
				if (count_q == '0) begin
					m_wdata = {addr_q, slot_q, 1'b0, 1'b0, anon_q};
					l_wdata = slot_q;
				end
			end
			S_LINK: begin
				// tail.next = new, head.prev = new
				m_we = up_next_we_q;
				m_waddr = tail_q;
				m_wdata = {up_frame_q, slot_q, up_flags_q};
				l_we = up_next_we_q;
				l_waddr = head_q;
				l_wdata = slot_q;
			end
			S_CHECK: begin
				// touch sets accessed, the hand walk clears it
				m_waddr = cur_q;
				m_wdata = {rd_frame, rd_next, !evict_q, rd_dirty | (!evict_q && write_q),
					rd_anon};
				m_we = evict_q ? (walk_q != '0 && rd_acc) : (kind_q == KIND_TOUCH && hit);
			end
			S_UNLINK_P: begin
				m_we = up_next_we_q;
				m_waddr = up_slot_q;
				m_wdata = {rd_frame, up_next_q, rd_acc, rd_dirty, rd_anon};
			end
			S_UNLINK_N: begin
				l_we = 1'b1;
				l_waddr = up_next_q;
				l_wdata = up_slot_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			hand_q <= '0;
			hand_valid_q <= 1'b0;
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						addr_q <= frame_addr;
						anon_q <= is_anon;
						write_q <= is_write;
						status <= ST_OK;
						victim_frame <= '0;
						needs_swap <= 1'b0;
						walk_q <= '0;
						evict_q <= (kind == KIND_EVICT);
						unique case (kind)
							KIND_ADD: begin
								if (count_q >= CB'(FRAMES)) begin
									status <= ST_FULL;
									state_q <= S_OUT;
									out_valid <= 1'b1;
								end else begin
									slot_q <= free_slot;
									state_q <= S_FREE_SLOT;
								end
							end
							KIND_FREE, KIND_TOUCH: begin
								cur_q <= head_q;
								state_q <= S_RD;
							end
							KIND_EVICT: begin
								if (count_q == '0) begin
									status <= ST_EMPTY;
									state_q <= S_OUT;
									out_valid <= 1'b1;
								end else begin
									// read the hand entry to find its successor
									cur_q <= hand_q;
									state_q <= S_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_FREE_SLOT: begin
					valid_q[slot_q] <= 1'b1;
					if (count_q == '0) begin
						head_q <= slot_q;
						tail_q <= slot_q;
						count_q <= count_q + 1'b1;
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end else begin
						// tail frame must be kept: read it before rewriting its next
						cur_q <= tail_q;
						up_next_we_q <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_LINK: begin
					if (up_next_we_q) begin
						tail_q <= slot_q;
						count_q <= count_q + 1'b1;
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end else begin
						up_frame_q <= rd_frame;
						up_flags_q <= {rd_acc, rd_dirty, rd_anon};
						up_next_we_q <= 1'b1;
					end
				end
				S_RD: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (kind_q == KIND_ADD) begin
						state_q <= S_LINK;
					end else if (evict_q) begin
						// rd_* holds the entry at cur_q (the hand entry on the first pass); step to successor
						if (walk_q == '0 && hand_valid_q) begin
							cur_q <= rd_next;
							walk_q <= walk_q + 1'b1;
							state_q <= S_RD;
						end else begin
							if (walk_q == '0) begin
								cur_q <= head_q;
								walk_q <= walk_q + 1'b1;
								hand_valid_q <= 1'b1;
								hand_q <= head_q;
								state_q <= S_RD;
							end else begin
								hand_q <= cur_q;
								hand_valid_q <= 1'b1;
								if (rd_acc) begin
									cur_q <= rd_next;
									state_q <= S_RD;
								end else begin
									victim_frame <= rd_frame;
									needs_swap <= rd_dirty | rd_anon;
									// remove the victim through the free path
									addr_q <= rd_frame;
									evict_q <= 1'b0;
									kind_q <= KIND_FREE;
									walk_q <= '0;
									state_q <= S_RD;
								end
							end
						end
					end else if (hit) begin
						if (kind_q == KIND_TOUCH) begin
							state_q <= S_OUT;
							out_valid <= 1'b1;
						end else begin
							valid_q[cur_q] <= 1'b0;
							if (count_q <= CB'(1)) begin
								count_q <= '0;
								hand_valid_q <= 1'b0;
								state_q <= S_OUT;
								out_valid <= 1'b1;
							end else begin
								if (cur_q == head_q) head_q <= rd_next;
								if (cur_q == tail_q) tail_q <= rd_prev;
								if (hand_valid_q && hand_q == cur_q) hand_q <= rd_prev;
								count_q <= count_q - 1'b1;
								up_slot_q <= rd_prev;
								up_next_q <= rd_next;
								// keep prev's frame: read it first
								slot_q <= cur_q;
								cur_q <= rd_prev;
								state_q <= S_UNLINK_P;
								up_next_we_q <= 1'b0;
							end
						end
					end else if (walk_q + 1'b1 >= count_q) begin
						status <= ST_NOT_FOUND;
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end else begin
						walk_q <= walk_q + 1'b1;
						cur_q <= rd_next;
						state_q <= S_RD;
					end
				end
				S_UNLINK_P: begin
					// first pass reads prev entry, second writes it
					if (!up_next_we_q) begin
						up_next_we_q <= 1'b1;
					end else begin
						state_q <= S_UNLINK_N;
					end
				end
				S_UNLINK_N: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// during the unlink write the prev entry's frame and flags come from the read port
	assign in_stall = (state_q != S_IDLE);

	// the first unlink cycle must not write before the frame is read
	logic unused_ok;
	assign unused_ok = m_we && state_q == S_UNLINK_P && !up_next_we_q;

	assert property (@(posedge clk) disable iff (!arst_n) !unused_ok)
		else $error("unlink wrote before reading");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(FRAMES)) else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("result outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !hand_valid_q || state_q != S_IDLE)
		else $error("hand set on empty table");
endmodule
`default_nettype wire

// ===== tb/sv/tb_clock_page_replacement_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_clock_page_replacement_checker #(
	parameter int FRAMES     = 64,
	parameter int FRAME_BITS = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire cpr_pkg::kind_t        kind,
	input  wire logic [FRAME_BITS-1:0] frame_addr,
	input  wire logic                  is_anon,
	input  wire logic                  is_write,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire cpr_pkg::status_t      status,
	input  wire logic [FRAME_BITS-1:0] victim_frame,
	input  wire logic                  needs_swap,
	output int                         fail_count,
	output int                         pending,
	output int                         resident
);
	import cpr_pkg::*;

	typedef struct packed {
		status_t               st;
		logic [FRAME_BITS-1:0] victim;
		logic                  swap;
	} answer_t;

	answer_t answers_due[$];

	logic [FRAME_BITS-1:0] frm [FRAMES];
	logic                  used [FRAMES];
	logic                  acc [FRAMES];
	logic                  dirty [FRAMES];
	logic                  anon [FRAMES];
	int                    nxt [FRAMES];
	int                    prv [FRAMES];
	int                    head, tail, hand, count;
	logic                  hand_set;

	initial begin
		fail_count = 0;
		pending = 0;
		for (int i = 0; i < FRAMES; i++) begin
			used[i] = 0; acc[i] = 0; dirty[i] = 0; anon[i] = 0;
			nxt[i] = 0; prv[i] = 0; frm[i] = '0;
		end
		head = 0; tail = 0; hand = 0; count = 0; hand_set = 0;
	end

	assign resident = count;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic int lookup(input logic [FRAME_BITS-1:0] a);
		int s;
		s = head;
		for (int i = 0; i < count; i++) begin
			if (used[s] && frm[s] == a) return s;
			s = nxt[s];
		end
		return -1;
	endfunction

	function automatic void drop_slot(input int s);
		if (count <= 1) begin
			count = 0;
			hand_set = 0;
		end else begin
			nxt[prv[s]] = nxt[s];
			prv[nxt[s]] = prv[s];
			if (s == head) head = nxt[s];
			if (s == tail) tail = prv[s];
			if (hand_set && hand == s) hand = prv[s];
			count--;
		end
		used[s] = 0; acc[s] = 0; dirty[s] = 0; anon[s] = 0;
	endfunction

	function automatic answer_t replace_step(input kind_t k, input logic [FRAME_BITS-1:0] a,
			input logic an, input logic wr);
		answer_t r;
		int s;
		r = '{st: ST_OK, victim: '0, swap: 1'b0};
		case (k)
			KIND_ADD: begin
				s = 0;
				while (s < FRAMES && used[s]) s++;
				if (count >= FRAMES || s >= FRAMES) begin
					r.st = ST_FULL;
				end else begin
					frm[s] = a; used[s] = 1; acc[s] = 0; dirty[s] = 0; anon[s] = an;
					if (count == 0) begin
						head = s; tail = s; nxt[s] = s; prv[s] = s;
					end else begin
						nxt[s] = head; prv[s] = tail;
						nxt[tail] = s; prv[head] = s;
						tail = s;
					end
					count++;
				end
			end
			KIND_FREE, KIND_TOUCH: begin
				s = lookup(a);
				if (s < 0) r.st = ST_NOT_FOUND;
				else if (k == KIND_FREE) drop_slot(s);
				else begin
					acc[s] = 1;
					if (wr) dirty[s] = 1;
				end
			end
			default: begin
				if (count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					for (int i = 0; i <= 2 * FRAMES; i++) begin
						if (!hand_set) begin
							hand = head;
							hand_set = 1;
						end else hand = nxt[hand];
						s = hand;
						if (acc[s]) begin
							acc[s] = 0;
							continue;
						end
						r.victim = frm[s];
						r.swap = dirty[s] | anon[s];
						drop_slot(s);
						break;
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				answers_due.push_back(replace_step(kind, frame_addr, is_anon, is_write));
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					report("unexpected transfer", 0, 0);
				end else begin
					want = answers_due.pop_front();
					if (status !== want.st) report("status", int'(status), int'(want.st));
					if (victim_frame !== want.victim)
						report("victim_frame", int'(victim_frame), int'(want.victim));
					if (needs_swap !== want.swap)
						report("needs_swap", int'(needs_swap), int'(want.swap));
				end
			end
		end
		pending = answers_due.size();
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb_clock_page_replacement_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_clock_page_replacement_top;
	import cpr_pkg::*;

	localparam int FRAMES     = 64;
	localparam int FRAME_BITS = 20;
	localparam int IDLE_LIMIT = 20000;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  in_valid = 0;
	logic                  in_stall;
	kind_t                 kind = KIND_ADD;
	logic [FRAME_BITS-1:0] frame_addr = '0;
	logic                  is_anon = 0;
	logic                  is_write = 0;
	logic                  out_valid;
	logic                  out_stall = 0;
	status_t               status;
	logic [FRAME_BITS-1:0] victim_frame;
	logic                  needs_swap;
	int                    fail_count, pending, resident;

	int  send_gap = 10;
	int  recv_gap = 69;
	bit  hold_out = 0;
	int  idle_cycles = 0;
	logic [FRAME_BITS-1:0] recent [16];

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	clock_page_replacement_top #(.FRAMES(FRAMES), .FRAME_BITS(FRAME_BITS)) dut (.*);

	tb_clock_page_replacement_checker #(.FRAMES(FRAMES), .FRAME_BITS(FRAME_BITS)) checker_i (
		.*
	);

	// receiver stall, random or held off for long stretches
	always @(negedge clk) out_stall <= hold_out || ($urandom_range(99) < recv_gap);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_clock_page_replacement_top: done, errors");
			$finish;
		end
	end

	task automatic offer(input kind_t k, input logic [FRAME_BITS-1:0] a,
			input logic an, input logic wr);
		while ($urandom_range(99) < send_gap) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; kind <= k; frame_addr <= a; is_anon <= an; is_write <= wr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic quiet_wait();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// mostly addresses seen recently so free and touch hit
	task automatic random_items(input int n);
		kind_t k;
		logic [FRAME_BITS-1:0] a;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			k = r < 35 ? KIND_ADD : r < 50 ? KIND_FREE : r < 80 ? KIND_TOUCH : KIND_EVICT;
			if (k == KIND_ADD && resident > 55 && $urandom_range(3) != 0) k = KIND_EVICT;
			a = $urandom_range(4) == 0 ? FRAME_BITS'($urandom) : recent[$urandom_range(15)];
			if (k == KIND_ADD) recent[$urandom_range(15)] = a;
			offer(k, a, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++) recent[i] = FRAME_BITS'($urandom);
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty, lone frame, extremes, unknown, duplicates, wrap
		offer(KIND_EVICT, '0, 1'b0, 1'b0);
		offer(KIND_FREE, '1, 1'b0, 1'b0);
		offer(KIND_TOUCH, '0, 1'b0, 1'b1);
		offer(KIND_ADD, '1, 1'b1, 1'b0);
		offer(KIND_TOUCH, '1, 1'b0, 1'b1);
		offer(KIND_EVICT, '0, 1'b0, 1'b0);
		offer(KIND_ADD, '0, 1'b0, 1'b0);
		offer(KIND_ADD, 20'h5a5a5, 1'b0, 1'b0);
		offer(KIND_ADD, '0, 1'b1, 1'b0);
		offer(KIND_TOUCH, '0, 1'b0, 1'b1);
		offer(KIND_TOUCH, 20'h5a5a5, 1'b0, 1'b0);
		offer(KIND_EVICT, '0, 1'b0, 1'b0);
		offer(KIND_FREE, '0, 1'b0, 1'b0);
		offer(KIND_EVICT, '0, 1'b0, 1'b0);
		offer(KIND_EVICT, '0, 1'b0, 1'b0);
		offer(KIND_EVICT, '0, 1'b0, 1'b0);
		// fill past capacity, then drain with hand wraps
		for (int i = 0; i < FRAMES + 2; i++) offer(KIND_ADD, FRAME_BITS'(i * 3), i[0], 1'b0);
		for (int i = 0; i < FRAMES; i += 2) offer(KIND_TOUCH, FRAME_BITS'(i * 3), 1'b0, i[1]);
		for (int i = 0; i < FRAMES + 1; i++) offer(KIND_EVICT, '0, 1'b0, 1'b0);
		quiet_wait();

		random_items(600);
		// long receiver hold-off while input keeps coming
		fork
			begin
				hold_out = 1;
				repeat (400) @(negedge clk);
				hold_out = 0;
			end
			random_items(40);
		join
		quiet_wait();

		send_gap = 69; recv_gap = 10;
		random_items(600);
		quiet_wait();
		send_gap = 0; recv_gap = 0;
		random_items(550);
		quiet_wait();

		if (fail_count == 0) $display("tb_clock_page_replacement_top: done, clean");
		else $display("tb_clock_page_replacement_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/cpr_pkg.sv
hdl/cpr_ram.sv
hdl/clock_page_replacement_top.sv
tb/sv/tb_clock_page_replacement_checker.sv
tb/sv/tb_clock_page_replacement_top.sv
